>>> rtl/core/i2crt_pkg.sv
// Shared types, codes and sizing constants of the I2C register transaction unit.
package i2crt_pkg;

	// Largest payload held in the write buffer.
	localparam int MAX_LENGTH = 16;
	localparam int CNT_W      = $clog2(MAX_LENGTH + 1);
	localparam int IDX_W      = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
	// Width used for length compares; holds any count plus two.
	localparam int CMP_W      = 9;

	// Configuration port sizing and register indexes.
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REGISTER  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd3;

	// Item opcodes.
	localparam logic [1:0] OP_START   = 2'd0;
	localparam logic [1:0] OP_STATUS  = 2'd1;
	localparam logic [1:0] OP_LOAD    = 2'd2;
	localparam logic [1:0] OP_TIMEOUT = 2'd3;

	// Controller status codes.
	localparam logic [7:0] ST_BUS_ERROR  = 8'h00;
	localparam logic [7:0] ST_START      = 8'h08;
	localparam logic [7:0] ST_RESTART    = 8'h10;
	localparam logic [7:0] ST_SLAW_ACK   = 8'h18;
	localparam logic [7:0] ST_SLAW_NACK  = 8'h20;
	localparam logic [7:0] ST_TX_ACK     = 8'h28;
	localparam logic [7:0] ST_TX_NACK    = 8'h30;
	localparam logic [7:0] ST_ARB_LOST   = 8'h38;
	localparam logic [7:0] ST_SLAR_ACK   = 8'h40;
	localparam logic [7:0] ST_RX_ACK     = 8'h50;
	localparam logic [7:0] ST_RX_NACK    = 8'h58;

	// Read bit OR-ed into the shifted slave address.
	localparam logic [7:0] SLA_READ_BIT = 8'h01;

	// Byte kinds.
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_DATA = 2'd1;
	localparam logic [1:0] KIND_RX   = 2'd2;

	// Fault codes.
	localparam logic [2:0] FAULT_NONE      = 3'd0;
	localparam logic [2:0] FAULT_ADDR_NACK = 3'd1;
	localparam logic [2:0] FAULT_DATA_NACK = 3'd2;
	localparam logic [2:0] FAULT_ARB_LOST  = 3'd3;
	localparam logic [2:0] FAULT_BUS_ERROR = 3'd4;
	localparam logic [2:0] FAULT_UNHANDLED = 3'd5;
	localparam logic [2:0] FAULT_TIMEOUT   = 3'd6;
	localparam logic [2:0] FAULT_OVERRUN   = 3'd7;

	// One input item.
	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] status_code;
		logic [7:0] received_byte;
		logic [3:0] load_index;
		logic [7:0] load_value;
	} in_item_t;

	// One result item.
	typedef struct packed {
		logic       control_write;
		logic       set_si;
		logic       set_sta;
		logic       set_sto;
		logic       set_aa;
		logic [1:0] byte_kind;
		logic [7:0] byte_value;
		logic       transfer_done;
		logic [2:0] fault;
		logic       interrupt_off;
		logic       last;
	} result_t;

	// Command passed from the front to the back: the first result and whether
	// a second control write follows it.
	typedef struct packed {
		result_t res;
		logic    second;
	} cmd_t;

	// Handshake between the command queue and the back part.
	typedef struct packed {
		logic valid;
		logic take;
	} cmd_hs_t;

endpackage

>>> rtl/core/i2crt_front.sv
// Front part: accepts items, holds configuration, counters and the write buffer.
module i2crt_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                accept,
	input  i2crt_pkg::in_item_t                 item,
	input  logic                                cfg_write,
	input  logic [i2crt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [i2crt_pkg::CFG_DAT_W-1:0]     cfg_data,
	output logic                                cmd_push,
	output i2crt_pkg::cmd_t                     cmd
);

	logic [6:0]                  target_q;
	logic [7:0]                  register_q;
	logic [4:0]                  length_q;
	logic                        direction_q;
	logic [i2crt_pkg::CNT_W-1:0] count_q;
	logic                        done_q;
	logic [7:0]                  buffer_q [i2crt_pkg::MAX_LENGTH];

	logic [i2crt_pkg::CMP_W-1:0] len_ext;
	logic [i2crt_pkg::CMP_W-1:0] cnt_ext;
	logic [i2crt_pkg::CMP_W-1:0] idx_ext;
	logic [i2crt_pkg::CMP_W-1:0] max_ext;
	logic [7:0]                  sla;
	logic                        rd;
	logic                        unhandled;
	logic                        emit;
	logic [i2crt_pkg::CNT_W-1:0] count_d;
	logic                        done_d;
	i2crt_pkg::result_t          res;
	logic                        second;

	// Effective length is clamped to the buffer size.
	assign max_ext = i2crt_pkg::CMP_W'(i2crt_pkg::MAX_LENGTH);
	assign len_ext = ({{(i2crt_pkg::CMP_W-5){1'b0}}, length_q} > max_ext) ? max_ext
		: {{(i2crt_pkg::CMP_W-5){1'b0}}, length_q};
	assign cnt_ext = i2crt_pkg::CMP_W'(count_q);
	assign idx_ext = {{(i2crt_pkg::CMP_W-4){1'b0}}, item.load_index};
	assign sla     = {target_q, 1'b0};
	assign rd      = direction_q;

	// Classify the item and work out its result and next state.
	always_comb begin
		res       = '0;
		second    = 1'b0;
		unhandled = 1'b0;
		emit      = 1'b0;
		count_d   = count_q;
		done_d    = done_q;
		case (item.opcode)
			i2crt_pkg::OP_START: begin
				emit              = 1'b1;
				count_d           = '0;
				done_d            = 1'b0;
				res.control_write = 1'b1;
				res.set_sta       = 1'b1;
			end
			i2crt_pkg::OP_STATUS: begin
				emit              = 1'b1;
				res.control_write = 1'b1;
				res.set_si        = 1'b1;
				case (item.status_code)
					i2crt_pkg::ST_START: begin
						res.byte_kind  = i2crt_pkg::KIND_DATA;
						res.byte_value = sla;
					end
					i2crt_pkg::ST_SLAW_ACK: begin
						res.byte_kind  = i2crt_pkg::KIND_DATA;
						res.byte_value = register_q;
					end
					i2crt_pkg::ST_TX_ACK: begin
						if (rd) begin
							if (len_ext != '0) begin
								res.set_sta = 1'b1;
							end else begin
								res.set_sto = 1'b1;
								done_d      = 1'b1;
							end
						end else if (cnt_ext < len_ext && cnt_ext < max_ext) begin
							res.byte_kind  = i2crt_pkg::KIND_DATA;
							res.byte_value = buffer_q[count_q[i2crt_pkg::IDX_W-1:0]];
							count_d        = count_q + 1'b1;
						end else begin
							res.set_sto = 1'b1;
							done_d      = 1'b1;
						end
					end
					i2crt_pkg::ST_SLAW_NACK: begin
						res.set_sto = 1'b1;
						res.fault   = i2crt_pkg::FAULT_ADDR_NACK;
						done_d      = 1'b1;
					end
					i2crt_pkg::ST_TX_NACK: begin
						res.set_sto = 1'b1;
						res.fault   = i2crt_pkg::FAULT_DATA_NACK;
						done_d      = 1'b1;
					end
					i2crt_pkg::ST_ARB_LOST: begin
						if (rd) begin
							res.set_sto = 1'b1;
						end else begin
							res.set_sta = 1'b1;
							res.set_aa  = 1'b1;
						end
						res.fault = i2crt_pkg::FAULT_ARB_LOST;
						done_d    = 1'b1;
					end
					i2crt_pkg::ST_BUS_ERROR: begin
						res.set_sto = 1'b1;
						res.set_aa  = 1'b1;
						res.fault   = i2crt_pkg::FAULT_BUS_ERROR;
						second      = 1'b1;
						done_d      = 1'b1;
					end
					i2crt_pkg::ST_RESTART: begin
						if (rd) begin
							res.byte_kind  = i2crt_pkg::KIND_DATA;
							res.byte_value = sla | i2crt_pkg::SLA_READ_BIT;
						end else begin
							unhandled = 1'b1;
						end
					end
					i2crt_pkg::ST_SLAR_ACK: begin
						if (rd) begin
							res.set_aa = (len_ext > i2crt_pkg::CMP_W'(1));
						end else begin
							unhandled = 1'b1;
						end
					end
					i2crt_pkg::ST_RX_ACK, i2crt_pkg::ST_RX_NACK: begin
						if (!rd) begin
							unhandled = 1'b1;
						end else if (cnt_ext >= len_ext) begin
							res.set_sto = 1'b1;
							res.fault   = i2crt_pkg::FAULT_OVERRUN;
							done_d      = 1'b1;
						end else begin
							count_d        = count_q + 1'b1;
							res.byte_kind  = i2crt_pkg::KIND_RX;
							res.byte_value = item.received_byte;
							if (item.status_code == i2crt_pkg::ST_RX_NACK) begin
								res.set_sto = 1'b1;
								done_d      = 1'b1;
							end else begin
								// ACK only while at least two more bytes remain.
								res.set_aa = (cnt_ext + i2crt_pkg::CMP_W'(2) < len_ext);
							end
						end
					end
					default: begin
						unhandled = 1'b1;
					end
				endcase
				if (unhandled) begin
					res.set_sto       = 1'b1;
					res.fault         = i2crt_pkg::FAULT_UNHANDLED;
					res.interrupt_off = 1'b1;
					done_d            = 1'b1;
				end
			end
			i2crt_pkg::OP_LOAD: begin
				emit = 1'b0;
			end
			default: begin
				emit      = 1'b1;
				res.fault = i2crt_pkg::FAULT_TIMEOUT;
				done_d    = 1'b1;
			end
		endcase
		res.transfer_done = done_d;
		res.last          = ~second;
	end

	assign cmd_push   = accept && emit;
	assign cmd.res    = res;
	assign cmd.second = second;

	// Configuration registers, byte count and end flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q    <= '0;
			register_q  <= '0;
			length_q    <= '0;
			direction_q <= 1'b0;
			count_q     <= '0;
			done_q      <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					i2crt_pkg::REG_TARGET:    target_q    <= cfg_data[6:0];
					i2crt_pkg::REG_REGISTER:  register_q  <= cfg_data;
					i2crt_pkg::REG_LENGTH:    length_q    <= cfg_data[4:0];
					i2crt_pkg::REG_DIRECTION: direction_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (accept) begin
				count_q <= count_d;
				done_q  <= done_d;
			end
		end
	end

	// Write buffer; loads beyond its size are dropped.
	always_ff @(posedge clk) begin
		if (accept && item.opcode == i2crt_pkg::OP_LOAD && idx_ext < max_ext) begin
			buffer_q[idx_ext[i2crt_pkg::IDX_W-1:0]] <= item.load_value;
		end
	end

endmodule

>>> rtl/core/i2crt_cmdq.sv
// Two-entry command queue between the front and the back part.
module i2crt_cmdq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  i2crt_pkg::cmd_t   push_cmd,
	output logic              full,
	output i2crt_pkg::cmd_hs_t hs_out,
	input  logic              take,
	output i2crt_pkg::cmd_t   head
);

	i2crt_pkg::cmd_t mem_q [2];
	logic            wptr_q;
	logic            rptr_q;
	logic [1:0]      count_q;
	logic            do_pop;

	assign full         = (count_q == 2'd2);
	assign hs_out.valid = (count_q != 2'd0);
	assign do_pop       = take && hs_out.valid;
	assign hs_out.take  = do_pop;
	assign head         = mem_q[rptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (do_pop) begin
				rptr_q <= ~rptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, do_pop};
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_cmd;
		end
	end

endmodule

>>> rtl/core/i2crt_back.sv
// Back part: expands commands into result items and holds the result queue.
module i2crt_back (
	input  logic                clk,
	input  logic                arst_n,
	input  i2crt_pkg::cmd_hs_t  cmd_hs,
	input  i2crt_pkg::cmd_t     cmd,
	output logic                cmd_take,
	output logic                empty,
	input  logic                pop,
	output i2crt_pkg::result_t  result
);

	i2crt_pkg::result_t mem_q [2];
	logic               wptr_q;
	logic               rptr_q;
	logic [1:0]         count_q;
	logic               pend_q;
	i2crt_pkg::result_t hold_q;

	logic               out_pop;
	logic               space;
	logic               wr;
	i2crt_pkg::result_t wr_res;
	i2crt_pkg::result_t hold_d;

	assign empty   = (count_q == 2'd0);
	assign out_pop = pop && !empty;
	assign space   = (count_q != 2'd2) || out_pop;
	assign result  = mem_q[rptr_q];

	// A pending second write goes first; otherwise take the next command.
	always_comb begin
		cmd_take = 1'b0;
		wr       = 1'b0;
		wr_res   = cmd.res;
		if (space) begin
			if (pend_q) begin
				wr     = 1'b1;
				wr_res = hold_q;
			end else if (cmd_hs.valid) begin
				wr       = 1'b1;
				cmd_take = 1'b1;
			end
		end
	end

	// The second write of a bus error drops STOP and ends the item.
	always_comb begin
		hold_d         = cmd.res;
		hold_d.set_sto = 1'b0;
		hold_d.last    = 1'b1;
	end

	// Result queue control and second-write tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			if (wr) begin
				wptr_q <= ~wptr_q;
			end
			if (out_pop) begin
				rptr_q <= ~rptr_q;
			end
			count_q <= count_q + {1'b0, wr} - {1'b0, out_pop};
			if (pend_q && space) begin
				pend_q <= 1'b0;
			end else if (cmd_take && cmd.second) begin
				pend_q <= 1'b1;
			end
		end
	end

	// Result storage and the held second write.
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wr_res;
		end
		if (cmd_take && cmd.second) begin
			hold_q <= hold_d;
		end
	end

endmodule

>>> rtl/core/i2c_master_register_transaction_unit.sv
// Top level of the I2C master register transaction unit.
// An accepted item is registered in the command queue, then in the result queue.
// One item per cycle in while the command queue is not full; one result per cycle
// written while the result queue has space, through the back part's single write port.
// Reset clears configuration, byte count, end flag and both queues at once;
// the write buffer is not cleared and holds its contents only once loaded.
module i2c_master_register_transaction_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  i2crt_pkg::in_item_t             in_item,
	output logic                            empty,
	input  logic                            pop,
	output i2crt_pkg::result_t              result,
	input  logic                            cfg_write,
	input  logic [i2crt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [i2crt_pkg::CFG_DAT_W-1:0] cfg_data
);

	logic               accept;
	logic               cmd_push;
	i2crt_pkg::cmd_t    cmd_in;
	i2crt_pkg::cmd_t    cmd_head;
	i2crt_pkg::cmd_hs_t cmd_hs;
	logic               cmd_take;

	assign accept = push && !full;

	// Front: classify items and update transfer state.
	i2crt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (in_item),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in)
	);

	// Queue decoupling the two parts.
	i2crt_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_cmd (cmd_in),
		.full     (full),
		.hs_out   (cmd_hs),
		.take     (cmd_take),
		.head     (cmd_head)
	);

	// Back: emit result items.
	i2crt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_hs   (cmd_hs),
		.cmd      (cmd_head),
		.cmd_take (cmd_take),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

>>> bench/tb.sv
// Self-checking testbench for the I2C master register transaction unit.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES = 800000;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD = 600;
	localparam int PHASE_ITEMS = 70;

	logic clk;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	i2crt_pkg::in_item_t in_item = '0;
	logic empty;
	logic pop = 1'b0;
	i2crt_pkg::result_t result;
	logic cfg_write = 1'b0;
	logic [i2crt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [i2crt_pkg::CFG_DAT_W-1:0] cfg_data = '0;

	i2c_master_register_transaction_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.in_item(in_item),
		.empty(empty),
		.pop(pop),
		.result(result),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Items waiting to be offered and results waiting to be seen.
	i2crt_pkg::in_item_t pending_items[$];
	i2crt_pkg::result_t expected_results[$];
	int items_queued = 0;
	int mismatches = 0;
	int cycle_count = 0;

	// Shadow of the configuration and of the sequencer state.
	logic [6:0] tgt_addr = '0;
	logic [7:0] reg_addr = '0;
	logic [4:0] xfer_len = '0;
	logic dir_rd = 1'b0;
	logic [7:0] payload_buf [i2crt_pkg::MAX_LENGTH];
	int byte_cnt = 0;
	logic done_bit = 1'b0;

	// Idle control for both sides.
	int tx_wait = 0;
	int tx_burst = 0;
	int rx_wait = 0;
	int rx_burst = 0;
	int hold_left = 0;
	int holds_done = 0;
	int hold_requests = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Gap length: mostly none or short, a few long, with idle-free bursts.
	function automatic int pick_gap(inout int burst);
		int r;
		if (burst > 0) begin
			burst--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5) begin
			burst = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic i2crt_pkg::result_t make_result(logic wr, logic si, logic sta,
			logic sto, logic aa, logic [1:0] kind, logic [7:0] value, logic [2:0] flt,
			logic ioff);
		i2crt_pkg::result_t r;
		r = '0;
		r.control_write = wr;
		r.set_si = si;
		r.set_sta = sta;
		r.set_sto = sto;
		r.set_aa = aa;
		r.byte_kind = kind;
		r.byte_value = (kind != i2crt_pkg::KIND_NONE) ? value : 8'h00;
		r.fault = flt;
		r.interrupt_off = ioff;
		return r;
	endfunction

	// Work out the results of one accepted item and queue them.
	task automatic predict_item(i2crt_pkg::in_item_t it);
		i2crt_pkg::result_t outs [0:1];
		int n;
		int eff;
		logic [7:0] sla;
		logic [7:0] code;
		eff = (xfer_len > i2crt_pkg::MAX_LENGTH) ? i2crt_pkg::MAX_LENGTH : int'(xfer_len);
		sla = {tgt_addr, 1'b0};
		code = it.status_code;
		n = 1;
		case (it.opcode)
			i2crt_pkg::OP_START: begin
				byte_cnt = 0;
				done_bit = 1'b0;
				outs[0] = make_result(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, i2crt_pkg::KIND_NONE,
					8'h00, i2crt_pkg::FAULT_NONE, 1'b0);
			end
			i2crt_pkg::OP_LOAD: begin
				payload_buf[it.load_index] = it.load_value;
				n = 0;
			end
			i2crt_pkg::OP_TIMEOUT: begin
				done_bit = 1'b1;
				outs[0] = make_result(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, i2crt_pkg::KIND_NONE,
					8'h00, i2crt_pkg::FAULT_TIMEOUT, 1'b0);
			end
			default: begin
				case (code)
					i2crt_pkg::ST_START: begin
						outs[0] = make_result(1'b1, 1'b1, 1'b0, 1'b0, 1'b0,
							i2crt_pkg::KIND_DATA, sla, i2crt_pkg::FAULT_NONE, 1'b0);
					end
					i2crt_pkg::ST_SLAW_ACK: begin
						outs[0] = make_result(1'b1, 1'b1, 1'b0, 1'b0, 1'b0,
							i2crt_pkg::KIND_DATA, reg_addr, i2crt_pkg::FAULT_NONE, 1'b0);
					end
					i2crt_pkg::ST_TX_ACK: begin
						if (dir_rd && eff > 0) begin
							// Register byte sent: turn the bus around with a repeated start.
							outs[0] = make_result(1'b1, 1'b1, 1'b1, 1'b0, 1'b0,
								i2crt_pkg::KIND_NONE, 8'h00, i2crt_pkg::FAULT_NONE, 1'b0);
						end else if (!dir_rd && byte_cnt < eff) begin
							outs[0] = make_result(1'b1, 1'b1, 1'b0, 1'b0, 1'b0,
								i2crt_pkg::KIND_DATA, payload_buf[4'(byte_cnt)],
								i2crt_pkg::FAULT_NONE, 1'b0);
							byte_cnt++;
						end else begin
							outs[0] = make_result(1'b1, 1'b1, 1'b0, 1'b1, 1'b0,
								i2crt_pkg::KIND_NONE, 8'h00, i2crt_pkg::FAULT_NONE, 1'b0);
							done_bit = 1'b1;
						end
					end
					i2crt_pkg::ST_SLAW_NACK, i2crt_pkg::ST_TX_NACK: begin
						outs[0] = make_result(1'b1, 1'b1, 1'b0, 1'b1, 1'b0,
							i2crt_pkg::KIND_NONE, 8'h00,
							(code == i2crt_pkg::ST_SLAW_NACK) ? i2crt_pkg::FAULT_ADDR_NACK
								: i2crt_pkg::FAULT_DATA_NACK, 1'b0);
						done_bit = 1'b1;
					end
					i2crt_pkg::ST_ARB_LOST: begin
						if (dir_rd)
							outs[0] = make_result(1'b1, 1'b1, 1'b0, 1'b1, 1'b0,
								i2crt_pkg::KIND_NONE, 8'h00, i2crt_pkg::FAULT_ARB_LOST, 1'b0);
						else
							outs[0] = make_result(1'b1, 1'b1, 1'b1, 1'b0, 1'b1,
								i2crt_pkg::KIND_NONE, 8'h00, i2crt_pkg::FAULT_ARB_LOST, 1'b0);
						done_bit = 1'b1;
					end
					i2crt_pkg::ST_BUS_ERROR: begin
						// Two control writes: STOP first, then release.
						outs[0] = make_result(1'b1, 1'b1, 1'b0, 1'b1, 1'b1,
							i2crt_pkg::KIND_NONE, 8'h00, i2crt_pkg::FAULT_BUS_ERROR, 1'b0);
						outs[1] = make_result(1'b1, 1'b1, 1'b0, 1'b0, 1'b1,
							i2crt_pkg::KIND_NONE, 8'h00, i2crt_pkg::FAULT_BUS_ERROR, 1'b0);
						n = 2;
						done_bit = 1'b1;
					end
					default: begin
						if (dir_rd && code == i2crt_pkg::ST_RESTART) begin
							outs[0] = make_result(1'b1, 1'b1, 1'b0, 1'b0, 1'b0,
								i2crt_pkg::KIND_DATA, sla | i2crt_pkg::SLA_READ_BIT,
								i2crt_pkg::FAULT_NONE, 1'b0);
						end else if (dir_rd && code == i2crt_pkg::ST_SLAR_ACK) begin
							outs[0] = make_result(1'b1, 1'b1, 1'b0, 1'b0, eff > 1,
								i2crt_pkg::KIND_NONE, 8'h00, i2crt_pkg::FAULT_NONE, 1'b0);
						end else if (dir_rd && (code == i2crt_pkg::ST_RX_ACK
								|| code == i2crt_pkg::ST_RX_NACK)) begin
							if (byte_cnt >= eff) begin
								// Byte beyond the programmed length is dropped.
								outs[0] = make_result(1'b1, 1'b1, 1'b0, 1'b1, 1'b0,
									i2crt_pkg::KIND_NONE, 8'h00, i2crt_pkg::FAULT_OVERRUN, 1'b0);
								done_bit = 1'b1;
							end else begin
								byte_cnt++;
								if (code == i2crt_pkg::ST_RX_NACK) begin
									outs[0] = make_result(1'b1, 1'b1, 1'b0, 1'b1, 1'b0,
										i2crt_pkg::KIND_RX, it.received_byte,
										i2crt_pkg::FAULT_NONE, 1'b0);
									done_bit = 1'b1;
								end else begin
									outs[0] = make_result(1'b1, 1'b1, 1'b0, 1'b0,
										(byte_cnt + 1) < eff, i2crt_pkg::KIND_RX,
										it.received_byte, i2crt_pkg::FAULT_NONE, 1'b0);
								end
							end
						end else begin
							outs[0] = make_result(1'b1, 1'b1, 1'b0, 1'b1, 1'b0,
								i2crt_pkg::KIND_NONE, 8'h00, i2crt_pkg::FAULT_UNHANDLED, 1'b1);
							done_bit = 1'b1;
						end
					end
				endcase
			end
		endcase
		for (int k = 0; k < n; k++) begin
			outs[k].transfer_done = done_bit;
			outs[k].last = (k == n - 1);
			expected_results.push_back(outs[k]);
		end
	endtask

	// Name of the first field that differs, or an empty string.
	function automatic string field_diff(i2crt_pkg::result_t e, i2crt_pkg::result_t a);
		if (a.control_write !== e.control_write) return "control_write";
		if (a.set_si !== e.set_si) return "set_si";
		if (a.set_sta !== e.set_sta) return "set_sta";
		if (a.set_sto !== e.set_sto) return "set_sto";
		if (a.set_aa !== e.set_aa) return "set_aa";
		if (a.byte_kind !== e.byte_kind) return "byte_kind";
		if (a.byte_value !== e.byte_value) return "byte_value";
		if (a.transfer_done !== e.transfer_done) return "transfer_done";
		if (a.fault !== e.fault) return "fault";
		if (a.interrupt_off !== e.interrupt_off) return "interrupt_off";
		if (a.last !== e.last) return "last";
		return "";
	endfunction

	task automatic report_mismatch(string what, i2crt_pkg::result_t e,
			i2crt_pkg::result_t a);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %0d at cycle %0d (%s): expected %h, got %h",
				mismatches, cycle_count, what, e, a);
	endtask

	// Driver: offers pending items, holds an item until it is taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				predict_item(in_item);
				tx_wait = pick_gap(tx_burst);
			end
			if (push && full) begin
				// Item still waiting; keep it on the port.
			end else if (tx_wait > 0) begin
				tx_wait--;
				push <= 1'b0;
			end else if (pending_items.size() > 0) begin
				push <= 1'b1;
				in_item <= pending_items.pop_front();
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Monitor: takes results and checks them against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					report_mismatch("no result expected", '0, result);
				end else if (field_diff(expected_results[0], result) != "") begin
					report_mismatch(field_diff(expected_results[0], result),
						expected_results[0], result);
					void'(expected_results.pop_front());
				end else begin
					void'(expected_results.pop_front());
				end
				rx_wait = pick_gap(rx_burst);
			end
			if (holds_done != hold_requests) begin
				hold_left = LONG_HOLD;
				holds_done++;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	function automatic i2crt_pkg::in_item_t rand_item(logic [1:0] op, logic [7:0] code);
		i2crt_pkg::in_item_t it;
		it.opcode = op;
		it.status_code = code;
		it.received_byte = 8'($urandom);
		it.load_index = 4'($urandom);
		it.load_value = 8'($urandom);
		return it;
	endfunction

	task automatic add_item(i2crt_pkg::in_item_t it);
		pending_items.push_back(it);
		items_queued++;
	endtask

	task automatic add_status(logic [7:0] code);
		add_item(rand_item(i2crt_pkg::OP_STATUS, code));
	endtask

	// Register write; the shadow copy follows at once since the block is idle.
	task automatic write_reg(logic [i2crt_pkg::CFG_IDX_W-1:0] idx,
			logic [i2crt_pkg::CFG_DAT_W-1:0] data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			i2crt_pkg::REG_TARGET: tgt_addr = data[6:0];
			i2crt_pkg::REG_REGISTER: reg_addr = data;
			i2crt_pkg::REG_LENGTH: xfer_len = data[4:0];
			default: dir_rd = data[0];
		endcase
	endtask

	// Unused upper data bits carry random junk.
	task automatic set_config(logic [6:0] tgt, logic [7:0] rg, logic [4:0] len, logic dir);
		logic [7:0] junk;
		junk = 8'($urandom);
		write_reg(i2crt_pkg::REG_TARGET, {junk[7], tgt});
		write_reg(i2crt_pkg::REG_REGISTER, rg);
		write_reg(i2crt_pkg::REG_LENGTH, {junk[2:0], len});
		write_reg(i2crt_pkg::REG_DIRECTION, {junk[6:0], dir});
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// Wait until every item is taken and every result seen, then let the pipe settle.
	task automatic wait_idle();
		@(negedge clk);
		while (pending_items.size() != 0 || push || expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One transaction for the current setting, sometimes cut short by a fault.
	task automatic gen_transaction();
		i2crt_pkg::in_item_t seq[$];
		int eff;
		int cut;
		int pick;
		eff = (xfer_len > i2crt_pkg::MAX_LENGTH) ? i2crt_pkg::MAX_LENGTH : int'(xfer_len);
		seq.push_back(rand_item(i2crt_pkg::OP_START, 8'($urandom)));
		seq.push_back(rand_item(i2crt_pkg::OP_STATUS, i2crt_pkg::ST_START));
		seq.push_back(rand_item(i2crt_pkg::OP_STATUS, i2crt_pkg::ST_SLAW_ACK));
		if (!dir_rd) begin
			repeat (eff + 1) seq.push_back(rand_item(i2crt_pkg::OP_STATUS, i2crt_pkg::ST_TX_ACK));
		end else begin
			seq.push_back(rand_item(i2crt_pkg::OP_STATUS, i2crt_pkg::ST_TX_ACK));
			if (eff > 0) begin
				seq.push_back(rand_item(i2crt_pkg::OP_STATUS, i2crt_pkg::ST_RESTART));
				seq.push_back(rand_item(i2crt_pkg::OP_STATUS, i2crt_pkg::ST_SLAR_ACK));
				repeat (eff - 1)
					seq.push_back(rand_item(i2crt_pkg::OP_STATUS, i2crt_pkg::ST_RX_ACK));
				seq.push_back(rand_item(i2crt_pkg::OP_STATUS, i2crt_pkg::ST_RX_NACK));
			end
			if ($urandom_range(0, 4) == 0)
				seq.push_back(rand_item(i2crt_pkg::OP_STATUS, $urandom_range(0, 1)
					? i2crt_pkg::ST_RX_ACK : i2crt_pkg::ST_RX_NACK));
		end
		if ($urandom_range(0, 99) < 15) begin
			cut = $urandom_range(1, seq.size() - 1);
			seq = seq[0:cut-1];
			pick = $urandom_range(0, 5);
			case (pick)
				0: seq.push_back(rand_item(i2crt_pkg::OP_STATUS, i2crt_pkg::ST_SLAW_NACK));
				1: seq.push_back(rand_item(i2crt_pkg::OP_STATUS, i2crt_pkg::ST_TX_NACK));
				2: seq.push_back(rand_item(i2crt_pkg::OP_STATUS, i2crt_pkg::ST_ARB_LOST));
				3: seq.push_back(rand_item(i2crt_pkg::OP_STATUS, i2crt_pkg::ST_BUS_ERROR));
				4: seq.push_back(rand_item(i2crt_pkg::OP_TIMEOUT, 8'($urandom)));
				default: seq.push_back(rand_item(i2crt_pkg::OP_STATUS, 8'($urandom)));
			endcase
		end
		foreach (seq[i]) add_item(seq[i]);
	endtask

	// Random part of one phase: transactions, buffer loads and noise.
	task automatic gen_phase(int count);
		int start_count;
		int r;
		start_count = items_queued;
		while (items_queued - start_count < count) begin
			r = $urandom_range(0, 99);
			if (r < 60)
				gen_transaction();
			else if (r < 75)
				add_item(rand_item(i2crt_pkg::OP_LOAD, 8'($urandom)));
			else
				add_item(rand_item(2'($urandom), 8'($urandom)));
		end
	endtask

	// Main sequence: reset, directed checks, then randomized phases.
	initial begin
		i2crt_pkg::in_item_t it;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: fill the whole buffer, one short write, then every fault but overrun.
		set_config(7'h7f, 8'hff, 5'd2, 1'b0);
		for (int i = 0; i < i2crt_pkg::MAX_LENGTH; i++) begin
			it = rand_item(i2crt_pkg::OP_LOAD, 8'($urandom));
			it.load_index = 4'(i);
			it.load_value = (i == 0) ? 8'h00 : (i == 1) ? 8'hff : 8'($urandom);
			add_item(it);
		end
		add_item(rand_item(i2crt_pkg::OP_START, 8'h00));
		add_status(i2crt_pkg::ST_START);
		add_status(i2crt_pkg::ST_SLAW_ACK);
		repeat (3) add_status(i2crt_pkg::ST_TX_ACK);
		add_status(i2crt_pkg::ST_SLAW_NACK);
		add_status(i2crt_pkg::ST_TX_NACK);
		add_status(i2crt_pkg::ST_ARB_LOST);
		add_status(i2crt_pkg::ST_BUS_ERROR);
		add_item(rand_item(i2crt_pkg::OP_TIMEOUT, 8'hff));
		// A read-only code during a write is not handled.
		add_status(i2crt_pkg::ST_SLAR_ACK);
		add_status(8'hff);
		wait_idle();

		for (int k = 0; k < 10; k++) begin
			case (k)
				0: set_config(7'h00, 8'h00, 5'd0, 1'b1);
				1: set_config(7'h7f, 8'hff, 5'd16, 1'b1);
				2: set_config(7'($urandom), 8'($urandom), 5'd1, 1'b1);
				3: set_config(7'($urandom), 8'($urandom), 5'd31, 1'b0);
				4: set_config(7'($urandom), 8'($urandom), 5'd0, 1'b0);
				5: set_config(7'($urandom), 8'($urandom), 5'd20, 1'b1);
				6: set_config(7'h7f, 8'hff, 5'd16, 1'b0);
				default: set_config(7'($urandom), 8'($urandom), 5'($urandom_range(0, 16)),
					1'($urandom_range(0, 1)));
			endcase
			// Long receiver stall while the sender keeps offering items.
			if (k == 3 || k == 8)
				hold_requests <= hold_requests + 1;
			gen_phase(PHASE_ITEMS);
			wait_idle();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
